FILE: design/skt_pkg.sv
package skt_pkg;

  localparam int KEY_W     = 32;
  localparam int MODE_W    = 2;
  localparam int SLOT_W    = 6;
  localparam int STATUS_W  = 3;
  localparam int WHERE_W   = 6;
  localparam int ENTRIES_W = 7;
  localparam int HINT_W    = 8;

  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 3'd4;

  localparam logic [HINT_W-1:0] HINT_INVALID = '1;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic             cmp;   // latch compare flags against key
    logic             ins;   // open a gap at the boundary and write key there
    logic             del;   // close the gap at slot
    logic [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage

FILE: design/skt_cell.sv
module skt_cell
  import skt_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [CNT_W-1:0]  count,
  input  logic [SLOT_W-1:0] del_slot,
  input  logic [KEY_W-1:0]  left_key,
  input  logic              left_ge,
  input  logic [KEY_W-1:0]  right_key,
  output logic [KEY_W-1:0]  key_o,
  output logic              ge_o,
  output logic              eq_o
);

  logic [KEY_W-1:0] key_r;
  logic             ge_r;
  logic             eq_r;
  logic             occupied;
  logic             at_or_above_slot;

  assign occupied         = 32'(IDX) < 32'(count);
  assign at_or_above_slot = 32'(IDX) >= 32'(del_slot);

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      // empty cells count as "not below the key" so the boundary stays monotonic
      ge_r <= !occupied || (key_r >= cmd.key);
      eq_r <= occupied && (key_r == cmd.key);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins && left_ge) begin
      key_r <= left_key;
    end else if (cmd.ins && ge_r) begin
      key_r <= cmd.key;
    end else if (cmd.del && at_or_above_slot) begin
      key_r <= right_key;
    end
  end

  assign key_o = key_r;
  assign ge_o  = ge_r;
  assign eq_o  = eq_r;

endmodule

FILE: design/sorted_key_table_core.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | in_mode, in_key, in_slot
// out_    | output    | out_valid/out_stall| out_status, out_where, out_entries
//
// The accept cycle latches compare flags in every cell; the apply state then
// encodes the boundary and shifts the whole cell row at once on insert/delete.
// in_stall is high while a request is being applied; apply waits for a free
// output register, so out_stall can hold the block indefinitely.
// Synchronous active-low reset empties the table and drops any pending output.
module sorted_key_table_core
  import skt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [SLOT_W-1:0]    in_slot,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic [WHERE_W-1:0]   out_where,
  output logic [ENTRIES_W-1:0] out_entries
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [HINT_W-1:0]    hint_r, hint_nxt;
  logic [MODE_W-1:0]    mode_r;
  logic [KEY_W-1:0]     key_r;
  logic [SLOT_W-1:0]    slot_r;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [WHERE_W-1:0]   out_where_r;
  logic [ENTRIES_W-1:0] out_entries_r;

  logic [KEY_W-1:0]     cell_key [CAPACITY];
  logic [CAPACITY-1:0]  cell_ge;
  logic [CAPACITY-1:0]  cell_eq;
  logic [CAPACITY-1:0]  bnd;
  logic [IDX_W-1:0]     pos;
  cell_cmd_t            cmd;

  logic in_fire, go, hit, is_del, is_ins, del_ok, del_go, ins_go, full;
  logic [STATUS_W-1:0]  status;
  logic [WHERE_W-1:0]   where_val;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign go       = (state_r == S_APPLY) && (!out_valid_r || !out_stall);

  // Boundary: first cell whose key is not below the search key.
  assign bnd = cell_ge & ~(cell_ge << 1);

  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnd[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  assign hit    = |cell_eq;
  assign is_del = (mode_r == MODE_DELETE);
  assign is_ins = (mode_r == MODE_INSERT);
  assign full   = 32'(count_r) >= 32'(CAPACITY);
  assign del_ok = 32'(slot_r) < 32'(count_r);
  assign del_go = go && is_del && del_ok;
  assign ins_go = go && !is_del && is_ins && !hit && !full;

  always_comb begin
    status    = ST_NOT_FOUND;
    where_val = '0;
    count_nxt = count_r;
    hint_nxt  = hint_r;
    priority if (is_del) begin
      if (del_ok) begin
        status    = ST_FOUND;
        count_nxt = count_r - CNT_W'(1);
        if ((32'(hint_r) < 32'(count_r)) && (32'(slot_r) <= 32'(hint_r))) begin
          hint_nxt = (32'(slot_r) < 32'(hint_r)) ? hint_r - HINT_W'(1) : HINT_INVALID;
        end
      end else begin
        status = ST_BAD_SLOT;
      end
    end else if (hit) begin
      status    = ST_FOUND;
      where_val = WHERE_W'(pos);
      hint_nxt  = HINT_W'(32'(pos) + 32'd1);
    end else if (!is_ins) begin
      status = ST_NOT_FOUND;
    end else if (full) begin
      status = ST_FULL;
    end else begin
      status    = ST_INSERTED;
      where_val = WHERE_W'(pos);
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_APPLY;
      S_APPLY: if (go)      state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign cmd.cmp = in_fire;
  assign cmd.ins = ins_go;
  assign cmd.del = del_go;
  assign cmd.key = in_fire ? in_key : key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      hint_r      <= HINT_INVALID;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        count_r     <= count_nxt;
        hint_r      <= hint_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_mode;
      key_r  <= in_key;
      slot_r <= in_slot;
    end
    if (go) begin
      out_status_r  <= status;
      out_where_r   <= where_val;
      out_entries_r <= ENTRIES_W'(count_nxt);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count_r),
      .del_slot  (slot_r),
      .left_key  ((i == 0) ? cell_key[0] : cell_key[(i == 0) ? 0 : i - 1]),
      .left_ge   ((i == 0) ? 1'b0 : cell_ge[(i == 0) ? 0 : i - 1]),
      .right_key (cell_key[(i == CAPACITY - 1) ? i : i + 1]),
      .key_o     (cell_key[i]),
      .ge_o      (cell_ge[i]),
      .eq_o      (cell_eq[i])
    );
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_where   = out_where_r;
  assign out_entries = out_entries_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(CAPACITY))
    else $error("entry count above capacity");

  a_bnd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |-> $onehot0(bnd))
    else $error("search boundary not unique");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ins_go |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow table");

  a_out_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_APPLY))
    else $error("result raised outside apply");

endmodule
